// ===== design/pwcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pwcf_pkg: shared types and constants of the window-cut filter
// Fixed widths of the event fields, the fixed-point format, the controller
// state type and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pwcf_pkg;

    // Field widths
    localparam int MEAS_W    = 20;
    localparam int COEF_W    = 32;
    localparam int POS_W     = 6;

    // Fixed-point format: saturation range is 48-bit signed
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 48;
    localparam int HALF_W    = VAL_W / 2;
    localparam int PROD_W    = 2 * VAL_W;
    // Square of a measure after the fraction shift
    localparam int SQ_W      = 2 * MEAS_W - FRAC_BITS;

    localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Table layout: eight words per cut, six bounds evaluated
    localparam int TERMS_PER_CUT = 8;
    localparam int TERM_W        = 3;
    localparam int CUT_W         = 3;
    localparam int NUM_BOUNDS    = 6;
    localparam logic [CUT_W-1:0] LAST_BOUND = CUT_W'(NUM_BOUNDS - 1);

    // Term positions inside one cut
    localparam logic [TERM_W-1:0] TERM_A0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_A1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_A3 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_A4 = 3'd4;
    localparam logic [TERM_W-1:0] TERM_A6 = 3'd6;
    localparam logic [TERM_W-1:0] TERM_A7 = 3'd7;

    // Request type codes
    localparam logic REQ_EVAL  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_DD,     // dist * dist
        MUL_LL,     // ls * ls
        MUL_CD,     // coefficient * d2
        MUL_LT1,    // ls * t1
        MUL_L2T2    // ls2 * t2
    } t_mul_sel;

    // Datapath register updates
    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_D2,     // d2   = product
        ALU_LS2,    // ls2  = product
        ALU_T1,     // t1   = coef + product
        ALU_T2,     // t2   = coef + product
        ALU_ACC0,   // acc  = coef + product
        ALU_ACC,    // acc  = acc + product
        ALU_CMP     // pass = pass & bound holds
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_D,
        S_SQ_D_W,
        S_SQ_L,
        S_SQ_L_W,
        S_RD_HI,
        S_MUL_C,
        S_MUL_C_W,
        S_ADD_C,
        S_MUL_T1,
        S_MUL_T1_W,
        S_MUL_T2,
        S_MUL_T2_W,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load;       // capture event fields, set pass
        logic              wr_en;      // store one coefficient
        logic              rd_en;      // read one table word
        logic [POS_W-1:0]  rd_pos;
        logic              mul_start;
        t_mul_sel          mul_sel;
        t_alu_op           alu_op;
        logic [CUT_W-1:0]  cut;
        logic              out_load;   // move pass into the output word
    } t_dp_cmd;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
    } t_dp_sts;

endpackage

// ===== design/pwcf_ram.sv =====
// ----------------------------------------------------------------------------
// pwcf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module pwcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/pwcf_mul.sv =====
// ----------------------------------------------------------------------------
// pwcf_mul: iterative saturating fixed-point multiplier
// Sign-magnitude product built from four 24x24 partial products, one per
// cycle, then shifted by the fraction width and saturated to 48 bits.
// ----------------------------------------------------------------------------
module pwcf_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [pwcf_pkg::VAL_W-1:0]   i_a,
    input  logic signed [pwcf_pkg::VAL_W-1:0]   i_b,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [pwcf_pkg::VAL_W-1:0]   o_p
);

    localparam int VW = pwcf_pkg::VAL_W;
    localparam int HW = pwcf_pkg::HALF_W;
    localparam int PW = pwcf_pkg::PROD_W;

    // Control
    logic       r_busy;
    logic       r_fin;
    logic [1:0] r_step;
    logic       r_done;

    // Payload
    logic [VW-1:0]          r_ma;
    logic [VW-1:0]          r_mb;
    logic                   r_neg;
    logic [PW-1:0]          r_acc;
    logic signed [VW-1:0]   r_p;

    logic [HW-1:0]          ca;
    logic [HW-1:0]          cb;
    logic [2*HW-1:0]        pp;
    logic [PW-1:0]          pp_sh;
    logic [PW-1:0]          q;
    logic                   big;
    logic signed [VW-1:0]   sat_p;

    // Pick the partial product of this step and align it
    always_comb begin
        ca = r_step[1] ? r_ma[VW-1:HW] : r_ma[HW-1:0];
        cb = r_step[0] ? r_mb[VW-1:HW] : r_mb[HW-1:0];
        pp = ca * cb;
        unique case (r_step)
            2'd0:    pp_sh = PW'(pp);
            2'd1,
            2'd2:    pp_sh = PW'(pp) << HW;
            default: pp_sh = PW'(pp) << (2 * HW);
        endcase
    end

    // Drop fraction bits, saturate, restore the sign
    always_comb begin
        q   = r_acc >> pwcf_pkg::FRAC_BITS;
        // a product past 64 bits saturates as well
        big = (|r_acc[PW-1:64]) || (|q[PW-1:VW-1]);
        if (r_neg) begin
            sat_p = big ? pwcf_pkg::SAT_MIN : -$signed(q[VW-1:0]);
        end else begin
            sat_p = big ? pwcf_pkg::SAT_MAX : $signed(q[VW-1:0]);
        end
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_step <= 2'd0;
            end else if (r_busy && !r_fin) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Capture magnitudes, accumulate, latch the result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[VW-1] ? VW'(-i_a) : VW'(i_a);
            r_mb  <= i_b[VW-1] ? VW'(-i_b) : VW'(i_b);
            r_neg <= i_a[VW-1] ^ i_b[VW-1];
            r_acc <= '0;
        end else if (r_busy && !r_fin) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) begin
            r_p <= sat_p;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_p;

`ifndef ASSERT_OFF
    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held longer than one cycle");
`endif

endmodule

// ===== design/pwcf_dp.sv =====
// ----------------------------------------------------------------------------
// pwcf_dp: window-cut datapath
// Holds the event word, the coefficient RAM, the shared multiplier, the
// saturating adder, the bound comparison and the output word.
// ----------------------------------------------------------------------------
module pwcf_dp #(
    parameter int NUM_CUTS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pwcf_pkg::t_dp_cmd                  i_cmd,
    output pwcf_pkg::t_dp_sts                  o_sts,
    input  logic [pwcf_pkg::POS_W-1:0]         i_coef_index,
    input  logic signed [pwcf_pkg::COEF_W-1:0] i_coef_value,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_img_width,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_img_length,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_src_dist,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_log_size,
    output logic                               o_passed
);

    localparam int VW     = pwcf_pkg::VAL_W;
    localparam int MW     = pwcf_pkg::MEAS_W;
    localparam int CW     = pwcf_pkg::COEF_W;
    localparam int SW     = pwcf_pkg::SQ_W;
    localparam int PSW    = pwcf_pkg::POS_W;
    localparam int FULL   = NUM_CUTS * pwcf_pkg::TERMS_PER_CUT;
    localparam int DEPTH  = (FULL > 2**PSW) ? 2**PSW : FULL;
    localparam int ADDR_W = $clog2(DEPTH);

    // Bound order: length, width, distance; lower then upper
    localparam logic [pwcf_pkg::CUT_W-1:0] BND_LEN_LO  = 3'd0;
    localparam logic [pwcf_pkg::CUT_W-1:0] BND_LEN_HI  = 3'd1;
    localparam logic [pwcf_pkg::CUT_W-1:0] BND_WID_LO  = 3'd2;
    localparam logic [pwcf_pkg::CUT_W-1:0] BND_WID_HI  = 3'd3;
    localparam logic [pwcf_pkg::CUT_W-1:0] BND_DIST_LO = 3'd4;

    function automatic logic signed [VW-1:0] sat_add(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            sat_add = s[VW] ? pwcf_pkg::SAT_MIN : pwcf_pkg::SAT_MAX;
        end else begin
            sat_add = s[VW-1:0];
        end
    endfunction

    // Event word and working values
    logic [MW-1:0]        r_width;
    logic [MW-1:0]        r_length;
    logic [MW-1:0]        r_dist;
    logic [MW-1:0]        r_ls;
    logic [SW-1:0]        r_d2;
    logic [SW-1:0]        r_ls2;
    logic signed [VW-1:0] r_t1;
    logic signed [VW-1:0] r_t2;
    logic signed [VW-1:0] r_acc;
    logic                 r_pass;
    logic                 r_passed;
    logic                 r_rd_zero;

    logic [CW-1:0]        rd_data;
    logic signed [VW-1:0] coef;
    logic signed [VW-1:0] mul_a;
    logic signed [VW-1:0] mul_b;
    logic signed [VW-1:0] mul_p;
    logic                 mul_busy;
    logic                 mul_done;
    logic                 wr_ok;
    logic                 rd_ok;
    logic [MW-1:0]        meas;
    logic signed [VW-1:0] meas_x;
    logic                 bound_ok;

    // Ignore writes and zero reads beyond the table
    assign wr_ok = i_cmd.wr_en && ({1'b0, i_coef_index} < (PSW+1)'(DEPTH));
    assign rd_ok = {1'b0, i_cmd.rd_pos} < (PSW+1)'(DEPTH);

    pwcf_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_ok),
        .i_wr_addr (i_coef_index[ADDR_W-1:0]),
        .i_wr_data (i_coef_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_pos[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Track whether the last read fell outside the table
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_zero <= !rd_ok;
        end
    end

    assign coef = r_rd_zero ? '0 : {{(VW-CW){rd_data[CW-1]}}, rd_data};

    // Select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            pwcf_pkg::MUL_DD: begin
                mul_a = {{(VW-MW){1'b0}}, r_dist};
                mul_b = {{(VW-MW){1'b0}}, r_dist};
            end
            pwcf_pkg::MUL_LL: begin
                mul_a = {{(VW-MW){1'b0}}, r_ls};
                mul_b = {{(VW-MW){1'b0}}, r_ls};
            end
            pwcf_pkg::MUL_CD: begin
                mul_a = coef;
                mul_b = {{(VW-SW){1'b0}}, r_d2};
            end
            pwcf_pkg::MUL_LT1: begin
                mul_a = {{(VW-MW){1'b0}}, r_ls};
                mul_b = r_t1;
            end
            pwcf_pkg::MUL_L2T2: begin
                mul_a = {{(VW-SW){1'b0}}, r_ls2};
                mul_b = r_t2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pwcf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign o_sts.mul_busy = mul_busy;
    assign o_sts.mul_done = mul_done;

    // Check the current bound: lower bounds want measure above the limit
    always_comb begin
        priority if (i_cmd.cut == BND_LEN_LO || i_cmd.cut == BND_LEN_HI) begin
            meas = r_length;
        end else if (i_cmd.cut == BND_WID_LO || i_cmd.cut == BND_WID_HI) begin
            meas = r_width;
        end else begin
            meas = r_dist;
        end
        meas_x = {{(VW-MW){1'b0}}, meas};
        if (i_cmd.cut == BND_LEN_LO || i_cmd.cut == BND_WID_LO ||
            i_cmd.cut == BND_DIST_LO) begin
            bound_ok = meas_x > r_acc;
        end else begin
            bound_ok = meas_x < r_acc;
        end
    end

    // Update working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_width  <= i_img_width;
            r_length <= i_img_length;
            r_dist   <= i_src_dist;
            r_ls     <= i_log_size;
            r_pass   <= 1'b1;
        end
        unique case (i_cmd.alu_op)
            pwcf_pkg::ALU_D2:   r_d2   <= mul_p[SW-1:0];
            pwcf_pkg::ALU_LS2:  r_ls2  <= mul_p[SW-1:0];
            pwcf_pkg::ALU_T1:   r_t1   <= sat_add(coef, mul_p);
            pwcf_pkg::ALU_T2:   r_t2   <= sat_add(coef, mul_p);
            pwcf_pkg::ALU_ACC0: r_acc  <= sat_add(coef, mul_p);
            pwcf_pkg::ALU_ACC:  r_acc  <= sat_add(r_acc, mul_p);
            pwcf_pkg::ALU_CMP:  r_pass <= r_pass & bound_ok;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_passed <= r_pass;
        end
    end

    assign o_passed = r_passed;

endmodule

// ===== design/pwcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwcf_ctrl: window-cut sequencer
// Accepts words, issues table writes, and steps the datapath through the
// squares and the six bound polynomials; owns the output valid flag.
// ----------------------------------------------------------------------------
module pwcf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pwcf_pkg::t_dp_cmd  o_cmd,
    input  pwcf_pkg::t_dp_sts  i_sts
);

    localparam int CUTW = pwcf_pkg::CUT_W;
    localparam int TW   = pwcf_pkg::TERM_W;

    pwcf_pkg::t_state  r_state, n_state;
    logic [CUTW-1:0]   r_cut, n_cut;
    logic [1:0]        r_k, n_k;
    logic              r_out_valid, n_out_valid;

    logic [TW-1:0]     term_hi;
    logic [TW-1:0]     term_lo;
    pwcf_pkg::t_alu_op lin_op;
    pwcf_pkg::t_dp_cmd cmd;

    // Linear terms of a cut: (a4,a3) -> t1, (a7,a6) -> t2, (a1,a0) -> acc
    always_comb begin
        unique case (r_k)
            2'd0: begin
                term_hi = pwcf_pkg::TERM_A4;
                term_lo = pwcf_pkg::TERM_A3;
                lin_op  = pwcf_pkg::ALU_T1;
            end
            2'd1: begin
                term_hi = pwcf_pkg::TERM_A7;
                term_lo = pwcf_pkg::TERM_A6;
                lin_op  = pwcf_pkg::ALU_T2;
            end
            default: begin
                term_hi = pwcf_pkg::TERM_A1;
                term_lo = pwcf_pkg::TERM_A0;
                lin_op  = pwcf_pkg::ALU_ACC0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwcf_pkg::S_IDLE;
            r_cut       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cut       <= n_cut;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_cut        = r_cut;
        n_k          = r_k;
        cmd          = '0;
        cmd.cut      = r_cut;
        cmd.rd_pos   = {r_cut, term_hi};
        cmd.mul_sel  = pwcf_pkg::MUL_CD;
        cmd.alu_op   = pwcf_pkg::ALU_NONE;

        unique case (r_state)
            pwcf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == pwcf_pkg::REQ_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.load = 1'b1;
                        n_state  = pwcf_pkg::S_SQ_D;
                    end
                end
            end
            pwcf_pkg::S_SQ_D: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pwcf_pkg::MUL_DD;
                n_state       = pwcf_pkg::S_SQ_D_W;
            end
            pwcf_pkg::S_SQ_D_W: begin
                if (i_sts.mul_done) begin
                    cmd.alu_op = pwcf_pkg::ALU_D2;
                    n_state    = pwcf_pkg::S_SQ_L;
                end
            end
            pwcf_pkg::S_SQ_L: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pwcf_pkg::MUL_LL;
                n_state       = pwcf_pkg::S_SQ_L_W;
            end
            pwcf_pkg::S_SQ_L_W: begin
                if (i_sts.mul_done) begin
                    cmd.alu_op = pwcf_pkg::ALU_LS2;
                    n_cut      = '0;
                    n_k        = '0;
                    n_state    = pwcf_pkg::S_RD_HI;
                end
            end
            pwcf_pkg::S_RD_HI: begin
                cmd.rd_en = 1'b1;
                n_state   = pwcf_pkg::S_MUL_C;
            end
            pwcf_pkg::S_MUL_C: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pwcf_pkg::MUL_CD;
                n_state       = pwcf_pkg::S_MUL_C_W;
            end
            pwcf_pkg::S_MUL_C_W: begin
                // fetch the constant term while the product holds
                if (i_sts.mul_done) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = {r_cut, term_lo};
                    n_state    = pwcf_pkg::S_ADD_C;
                end
            end
            pwcf_pkg::S_ADD_C: begin
                cmd.alu_op = lin_op;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = pwcf_pkg::S_MUL_T1;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = pwcf_pkg::S_RD_HI;
                end
            end
            pwcf_pkg::S_MUL_T1: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pwcf_pkg::MUL_LT1;
                n_state       = pwcf_pkg::S_MUL_T1_W;
            end
            pwcf_pkg::S_MUL_T1_W: begin
                if (i_sts.mul_done) begin
                    cmd.alu_op = pwcf_pkg::ALU_ACC;
                    n_state    = pwcf_pkg::S_MUL_T2;
                end
            end
            pwcf_pkg::S_MUL_T2: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pwcf_pkg::MUL_L2T2;
                n_state       = pwcf_pkg::S_MUL_T2_W;
            end
            pwcf_pkg::S_MUL_T2_W: begin
                if (i_sts.mul_done) begin
                    cmd.alu_op = pwcf_pkg::ALU_ACC;
                    n_state    = pwcf_pkg::S_CMP;
                end
            end
            pwcf_pkg::S_CMP: begin
                cmd.alu_op = pwcf_pkg::ALU_CMP;
                if (r_cut == pwcf_pkg::LAST_BOUND) begin
                    n_state = pwcf_pkg::S_DONE;
                end else begin
                    n_cut   = r_cut + CUTW'(1);
                    n_state = pwcf_pkg::S_RD_HI;
                end
            end
            pwcf_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = pwcf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pwcf_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when the word is taken
    always_comb begin
        priority if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != pwcf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // Never restart the shared multiplier while it is working
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_start |-> !i_sts.mul_busy)
        else $error("multiplier started while busy");

    // A finished product only arrives in a wait state
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> (r_state == pwcf_pkg::S_SQ_D_W ||
                            r_state == pwcf_pkg::S_SQ_L_W ||
                            r_state == pwcf_pkg::S_MUL_C_W ||
                            r_state == pwcf_pkg::S_MUL_T1_W ||
                            r_state == pwcf_pkg::S_MUL_T2_W))
        else $error("multiplier result arrived outside a wait state");

    // Loading the output word presents it next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("output word loaded but not presented");
`endif

endmodule

// ===== design/polynomial_window_cut_filter_top.sv =====
// ----------------------------------------------------------------------------
// polynomial_window_cut_filter_top: polynomial window-cut event filter
// Stores cut coefficients one word at a time and judges events against six
// bounds, each a saturating fixed-point polynomial in log-size and d^2.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | req_type, coef_index,
//           |           |                         | coef_value, img_width,
//           |           |                         | img_length, src_dist,
//           |           |                         | log_size
//   out     | output    | o_out_valid/i_out_stall | passed
//
// A coefficient write gives no result. An event runs from acceptance to
// result through 32 products on the one shared multiplier, each built from
// 24x24 partial products, plus table reads, adds and a compare per cut;
// no new word is accepted until the result is loaded for output.
// Reset clears the sequencer and output valid; the table is not cleared.
// A result that waits under stall holds in the output register; the next
// word is accepted meanwhile, and a finished event waits only if the
// output register is still full.
// ----------------------------------------------------------------------------
module polynomial_window_cut_filter_top #(
    parameter int NUM_CUTS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [pwcf_pkg::POS_W-1:0]         i_coef_index,
    input  logic signed [pwcf_pkg::COEF_W-1:0] i_coef_value,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_img_width,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_img_length,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_src_dist,
    input  logic [pwcf_pkg::MEAS_W-1:0]        i_log_size,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_passed
);

    pwcf_pkg::t_dp_cmd cmd;
    pwcf_pkg::t_dp_sts sts;

    // Sequencer
    pwcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath
    pwcf_dp #(
        .NUM_CUTS (NUM_CUTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_img_width  (i_img_width),
        .i_img_length (i_img_length),
        .i_src_dist   (i_src_dist),
        .i_log_size   (i_log_size),
        .o_passed     (o_passed)
    );

endmodule
